[sv/mprf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_pkg
// Shared types for the smallest primitive root finder.
// ----------------------------------------------------------------------------
package mprf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FDIV,
    ST_FWAIT,
    ST_FSTRIP,
    ST_FSWAIT,
    ST_FNEXT,
    ST_EXPO,
    ST_EWAIT,
    ST_GTRY,
    ST_PWAIT,
    ST_GNEXT,
    ST_DONE
  } state_t;

endpackage

[sv/mprf_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_divider
// Restoring divider, one quotient bit per cycle. Gives quotient and remainder.
// ----------------------------------------------------------------------------
module mprf_divider #(
  parameter int W = 62
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r, q_r[W-1]};
    if (start) begin
      q_nxt    = num;
      r_nxt    = '0;
      d_nxt    = den;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = W'(trial - {1'b0, d_r});
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

[sv/mprf_modmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_modmul
// Bit-serial modular multiplier: shift-and-add, reducing after each double and add.
// ----------------------------------------------------------------------------
module mprf_modmul #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W+1:0]  dbl, sum;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dbl = {1'b0, acc_r, 1'b0};
    if (dbl >= {2'b0, m_r}) dbl = dbl - {2'b0, m_r};
    sum = dbl + (b_r[W-1] ? {2'b0, a_r} : '0);
    if (sum >= {2'b0, m_r}) sum = sum - {2'b0, m_r};
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      m_nxt    = m;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum[W-1:0];
      b_nxt   = {b_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[sv/mprf_modpow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_modpow
// Square-and-multiply exponentiation, exponent scanned from the top bit down,
// one serial modular multiplication at a time.
// ----------------------------------------------------------------------------
module mprf_modpow #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] base,
  input  logic [W-1:0] expo,
  input  logic [W-1:0] m,
  output logic         done,
  output logic         is_one
);

  localparam int CW = $clog2(W + 1);

  // Phase 0 squares the accumulator, phase 1 multiplies by the base.
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          wait_r, wait_nxt;
  logic          ph_r, ph_nxt;
  logic          done_r, done_nxt;
  logic          mm_start;
  logic [W-1:0]  mm_b;
  logic          mm_done;
  logic [W-1:0]  mm_prod;

  mprf_modmul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (acc_r),
    .b     (mm_b),
    .m     (m),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  assign mm_b = ph_r ? base : acc_r;

  always_comb begin
    acc_nxt  = acc_r;
    e_nxt    = e_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    wait_nxt = wait_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    mm_start = 1'b0;
    if (start) begin
      acc_nxt  = W'(1);
      e_nxt    = expo;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
      wait_nxt = 1'b0;
      ph_nxt   = 1'b0;
    end else if (busy_r) begin
      if (!wait_r) begin
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else if (ph_r && !e_r[W-1]) begin
          ph_nxt  = 1'b0;
          e_nxt   = {e_r[W-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          mm_start = 1'b1;
          wait_nxt = 1'b1;
        end
      end else if (mm_done) begin
        acc_nxt  = mm_prod;
        wait_nxt = 1'b0;
        if (ph_r) begin
          ph_nxt  = 1'b0;
          e_nxt   = {e_r[W-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          ph_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wait_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      wait_r <= wait_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    e_r   <= e_nxt;
  end

  // Modulus is at least three here, so one is already reduced.
  assign done   = done_r;
  assign is_one = (acc_r == W'(1));

endmodule

[sv/min_primitive_root_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_primitive_root_finder
// Finds the smallest primitive root of a prime modulus.
//
//   Channel  Direction  Content
//   in_      slave      tdata[30:0] modulus
//   out_     master     tdata[30:0] generator, tuser not_found
//
// One item at a time. Each trial divisor of p-1, up to the square root of the
// unfactored part, takes one serial division, and a found factor is then
// stripped by further divisions. Per candidate g and factor q, (p-1)/q takes
// one serial division and the power VALUE_BITS squarings plus a multiply
// per set exponent bit. A held result blocks the next input transfer.
// Reset is synchronous and active low and clears only control state.
// ----------------------------------------------------------------------------
module min_primitive_root_finder #(
  parameter int VALUE_BITS  = 31,
  parameter int MAX_FACTORS = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] modulus
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] generator
  output logic        out_tuser   // [0] not_found
);

  localparam int W  = VALUE_BITS;
  localparam int DW = 2 * VALUE_BITS;
  localparam int FW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam int NW = $clog2(MAX_FACTORS + 1);

  mprf_pkg::state_t state_r, state_nxt;

  logic [W-1:0]  p_r, p_nxt;
  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [DW-1:0] sq_r, sq_nxt;
  logic [W-1:0]  g_r, g_nxt;
  logic [W-1:0]  fac_r [MAX_FACTORS];
  logic [W-1:0]  fac_nxt;
  logic          fac_we;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [FW-1:0] k_r, k_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          nf_r, nf_nxt;

  logic          dv_start, dv_done;
  logic [DW-1:0] dv_num, dv_den, dv_quo, dv_rem;
  logic          pw_start, pw_done, pw_one;
  logic [W-1:0]  in_p;
  logic [W-1:0]  kfac;

  assign in_p = in_tdata[W-1:0];
  assign kfac = fac_r[k_r];

  mprf_divider #(.W(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo),
    .rem   (dv_rem)
  );

  mprf_modpow #(.W(W)) u_pow (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (pw_start),
    .base   (g_r),
    .expo   (dv_quo[W-1:0]),
    .m      (p_r),
    .done   (pw_done),
    .is_one (pw_one)
  );

  // Next state and datapath.
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    g_nxt     = g_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    nf_nxt    = nf_r;
    fac_nxt   = d_r;
    fac_we    = 1'b0;
    unique case (state_r)
      mprf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          p_nxt   = in_p;
          n_nxt   = in_p - W'(1);
          d_nxt   = W'(2);
          sq_nxt  = DW'(4);
          cnt_nxt = '0;
          res_nxt = '0;
          nf_nxt  = 1'b1;
          if (in_p < W'(3)) state_nxt = mprf_pkg::ST_DONE;
          else state_nxt = mprf_pkg::ST_FDIV;
        end
      end
      mprf_pkg::ST_FDIV: begin
        if (sq_r > DW'(n_r)) begin
          if (n_r > W'(1) && cnt_r < NW'(MAX_FACTORS)) begin
            fac_nxt = n_r;
            fac_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = mprf_pkg::ST_EXPO;
          g_nxt     = W'(2);
          k_nxt     = '0;
        end else begin
          state_nxt = mprf_pkg::ST_FWAIT;
        end
      end
      mprf_pkg::ST_FWAIT: begin
        if (dv_done) begin
          if (dv_rem == '0) begin
            if (cnt_r < NW'(MAX_FACTORS)) begin
              fac_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
            n_nxt     = dv_quo[W-1:0];
            state_nxt = mprf_pkg::ST_FSTRIP;
          end else begin
            state_nxt = mprf_pkg::ST_FNEXT;
          end
        end
      end
      mprf_pkg::ST_FSTRIP: state_nxt = mprf_pkg::ST_FSWAIT;
      mprf_pkg::ST_FSWAIT: begin
        if (dv_done) begin
          if (dv_rem == '0) begin
            n_nxt     = dv_quo[W-1:0];
            state_nxt = mprf_pkg::ST_FSTRIP;
          end else begin
            state_nxt = mprf_pkg::ST_FNEXT;
          end
        end
      end
      mprf_pkg::ST_FNEXT: begin
        d_nxt     = d_r + W'(1);
        sq_nxt    = sq_r + DW'({d_r, 1'b1});
        state_nxt = mprf_pkg::ST_FDIV;
      end
      mprf_pkg::ST_EXPO: begin
        if (g_r >= p_r) state_nxt = mprf_pkg::ST_DONE;
        else if (NW'(k_r) >= cnt_r) begin
          res_nxt   = g_r;
          nf_nxt    = 1'b0;
          state_nxt = mprf_pkg::ST_DONE;
        end else state_nxt = mprf_pkg::ST_EWAIT;
      end
      mprf_pkg::ST_EWAIT: if (dv_done) state_nxt = mprf_pkg::ST_GTRY;
      mprf_pkg::ST_GTRY:  state_nxt = mprf_pkg::ST_PWAIT;
      mprf_pkg::ST_PWAIT: begin
        if (pw_done) begin
          if (pw_one) state_nxt = mprf_pkg::ST_GNEXT;
          else begin
            if (NW'(k_r) + NW'(1) >= cnt_r) k_nxt = FW'(MAX_FACTORS - 1);
            else k_nxt = k_r + FW'(1);
            if (NW'(k_r) + NW'(1) >= cnt_r) begin
              res_nxt   = g_r;
              nf_nxt    = 1'b0;
              state_nxt = mprf_pkg::ST_DONE;
            end else state_nxt = mprf_pkg::ST_EWAIT;
          end
        end
      end
      mprf_pkg::ST_GNEXT: begin
        g_nxt     = g_r + W'(1);
        k_nxt     = '0;
        state_nxt = mprf_pkg::ST_EXPO;
      end
      mprf_pkg::ST_DONE: if (out_tready) state_nxt = mprf_pkg::ST_IDLE;
      default: state_nxt = mprf_pkg::ST_IDLE;
    endcase
  end

  // Outputs and unit starts.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    dv_start   = 1'b0;
    pw_start   = 1'b0;
    dv_num     = DW'(n_r);
    dv_den     = DW'(d_r);
    unique case (state_r)
      mprf_pkg::ST_IDLE: in_tready = 1'b1;
      mprf_pkg::ST_FDIV: dv_start = !(sq_r > DW'(n_r));
      mprf_pkg::ST_FSTRIP: dv_start = 1'b1;
      mprf_pkg::ST_EXPO: begin
        dv_num   = DW'(p_r - W'(1));
        dv_den   = DW'(kfac);
        dv_start = (g_r < p_r) && (NW'(k_r) < cnt_r);
      end
      mprf_pkg::ST_PWAIT: begin
        dv_num   = DW'(p_r - W'(1));
        dv_den   = DW'(fac_r[k_nxt]);
        dv_start = pw_done && !pw_one && (NW'(k_r) + NW'(1) < cnt_r);
      end
      mprf_pkg::ST_GTRY: pw_start = 1'b1;
      mprf_pkg::ST_DONE: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mprf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    p_r   <= p_nxt;
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    g_r   <= g_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
    nf_r  <= nf_nxt;
    if (fac_we) fac_r[cnt_r[FW-1:0]] <= fac_nxt;
  end

  assign out_tdata = 32'(res_r);
  assign out_tuser = nf_r;

endmodule

[sim/tb_min_primitive_root_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_primitive_root_finder
// Self-checking testbench for the smallest primitive root finder.
//
// Moduli are sent on the input stream, and each one is also handed to a
// scoreboard. The scoreboard works out the expected smallest primitive root
// and checks every result transfer against it, in order. Directed edge
// values come first. Random moduli follow, most of them primes below 4096,
// under four patterns of input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb_min_primitive_root_finder;

  localparam int VALUE_BITS  = 31;
  localparam int MAX_FACTORS = 9;
  localparam longint CYCLE_LIMIT = 64'd60_000_000;

  typedef struct packed {
    logic [30:0] generator;
    logic        not_found;
  } root_t;

  class root_scoreboard;
    root_t pending[$];

    function automatic longint pow_mod(longint b, longint e, longint m);
      longint acc;
      acc = 1 % m;
      b = b % m;
      while (e != 0) begin
        if (e[0]) acc = (acc * b) % m;
        e = e >> 1;
        b = (b * b) % m;
      end
      return acc;
    endfunction

    function automatic root_t smallest_root(logic [30:0] modulus);
      longint p, n, d, g;
      longint expo[MAX_FACTORS];
      int cnt;
      bit good;
      root_t r;
      r.generator = '0;
      r.not_found = 1'b1;
      p = modulus;
      if (p < 3) return r;
      n = p - 1;
      cnt = 0;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          if (cnt < MAX_FACTORS) begin
            expo[cnt] = (p - 1) / d;
            cnt++;
          end
          while (n % d == 0) n = n / d;
        end
      end
      if (n > 1 && cnt < MAX_FACTORS) begin
        expo[cnt] = (p - 1) / n;
        cnt++;
      end
      for (g = 2; g < p; g++) begin
        good = 1'b1;
        for (int k = 0; k < cnt; k++) begin
          if (pow_mod(g, expo[k], p) == 1) begin
            good = 1'b0;
            break;
          end
        end
        if (good) begin
          r.generator = g[30:0];
          r.not_found = 1'b0;
          return r;
        end
      end
      return r;
    endfunction

    function void note_modulus(logic [30:0] modulus);
      pending.insert(pending.size(), smallest_root(modulus));
    endfunction

    function bit check_root(logic [30:0] generator, logic not_found, output string why);
      root_t want;
      if (pending.size() == 0) begin
        why = $sformatf("unexpected result generator=%0d not_found=%0b",
                        generator, not_found);
        return 1'b0;
      end
      want = pending.pop_front();
      if (generator !== want.generator || not_found !== want.not_found) begin
        why = $sformatf("got generator=%0d not_found=%0b, expected %0d/%0b",
                        generator, not_found, want.generator, want.not_found);
        return 1'b0;
      end
      why = "";
      return 1'b1;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  root_scoreboard sb;
  int errors = 0;
  int gap_pct;
  int stall_pct;
  longint cycles = 0;

  min_primitive_root_finder #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_FACTORS(MAX_FACTORS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report(string why);
    errors++;
    $display("ERROR at %0t: %s", $realtime, why);
  endtask

  always @(posedge clk) begin
    string why;
    if (rst_n && out_tvalid && out_tready) begin
      if (!sb.check_root(out_tdata[30:0], out_tuser, why)) report(why);
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL min_primitive_root_finder");
      $finish;
    end
  end

  task automatic send_modulus(logic [30:0] modulus);
    int gap;
    gap = 0;
    if ($urandom_range(99) < gap_pct) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, modulus};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_modulus(modulus);
  endtask

  function automatic bit is_prime(int unsigned n);
    if (n < 2) return 1'b0;
    for (int unsigned d = 2; d * d <= n; d++)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_random_modulus();
    int unsigned v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) v = $urandom_range(20'hFFFFF, 20'h10000);
    else v = $urandom_range(4095);
    if (pick >= 30) begin
      while (!is_prime(v)) v = (v >= 4093) ? 2 : v + 1;
    end
    send_modulus(v[30:0]);
  endtask

  initial begin
    logic [30:0] directed[$];
    sb = new();
    gap_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{0, 1, 2, 3, 4, 5, 7, 9, 15, 23, 41, 191, 409, 1021, 4093,
                 7919, 65537, 1000003, 31'h2AAAAAAA, 31'h55555555,
                 31'h7FFFFFFF};
    foreach (directed[i]) send_modulus(directed[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      repeat (20) send_random_modulus();
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS min_primitive_root_finder");
    end else begin
      $display("FAIL min_primitive_root_finder");
    end
    $finish;
  end

endmodule
